[hdl/sgd_pkg.sv]
// Shared widths, defaults and the signed mapping for the signed Elias gamma decoder.
package sgd_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned VAL_W          = 31;
    localparam int unsigned RUN_W          = 5;
    localparam int unsigned SLOT_W         = $clog2(BYTE_W);
    localparam int unsigned MAX_PREFIX_DEF = 30;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [RUN_W-1:0]  t_run;
    typedef logic [SLOT_W-1:0] t_slot;

    // odd b gives (b-1)/2, even b gives -(b/2), both modulo 2^VAL_W
    function automatic t_val map_signed(input t_val b);
        t_val half;
        half = b >> 1;
        if (b[0]) begin
            map_signed = half;
        end else begin
            map_signed = t_val'(~half + t_val'(1));
        end
    endfunction

endpackage

[hdl/signed_elias_gamma_decoder.sv]
// Signed Elias gamma decoder: byte input register, byte-wide decode, per-bit result register.
//
// Input channel: i_in_valid / o_in_ready carry one byte of code bits, MSB first,
// on i_data_byte. Output channel: o_out_valid / i_out_ready carry one decoded
// result per transfer (o_decoded_value, o_prefix_error, o_last_of_byte).
// A byte yields zero to eight results; o_last_of_byte marks the final one of
// each byte. Bytes that only extend a zero prefix yield nothing.
// A transferred byte waits in the input register, is decoded as it loads into
// the result register, and its results transfer from there.
// Throughput: one byte per cycle while each byte yields at most one result
// and i_out_ready stays high; a byte with several results occupies the output
// port until its last one is taken. The output port, one result per transfer, sets the rate.
// The input register keeps taking a byte while results of the previous byte
// still wait, so a stall on the output holds one extra byte, then o_in_ready
// falls until the last result of the pending byte is taken.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// decoder to counting a fresh zero prefix.
module signed_elias_gamma_decoder #(
    parameter int unsigned MAX_PREFIX = sgd_pkg::MAX_PREFIX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sgd_pkg::t_byte      i_data_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [sgd_pkg::VAL_W-1:0] o_decoded_value,
    output logic                o_prefix_error,
    output logic                o_last_of_byte
);
    import sgd_pkg::*;

    localparam t_run MaxRun = t_run'(MAX_PREFIX);

    // input register
    logic               r_in_vld;
    t_byte              r_in_byte;

    // decoder state
    t_run               r_zero_run,   n_zero_run;
    logic               r_collecting, n_collecting;
    t_run               r_bits_left,  n_bits_left;
    t_val               r_acc,        n_acc;

    // result register, one slot per code bit of the byte
    logic [BYTE_W-1:0]  r_res_vld,    n_res_vld;
    logic [BYTE_W-1:0]  r_res_err,    n_res_err;
    t_val               r_res_b [BYTE_W];
    t_val               n_res_b [BYTE_W];

    t_slot              w_sel;
    logic               w_fire_out;
    logic               w_res_free;
    logic               w_load;

    // --- drain side: earliest code bit first, i.e. highest slot ---
    always_comb begin
        w_sel = '0;
        for (int i = 0; i < int'(BYTE_W); i++) begin
            if (r_res_vld[i]) begin
                w_sel = t_slot'(i);
            end
        end
    end

    assign o_out_valid     = |r_res_vld;
    assign o_decoded_value = map_signed(r_res_b[w_sel]);
    assign o_prefix_error  = r_res_err[w_sel];
    assign o_last_of_byte  = ((r_res_vld & (r_res_vld - BYTE_W'(1))) == '0);

    assign w_fire_out = o_out_valid & i_out_ready;
    assign w_res_free = !o_out_valid || (w_fire_out && o_last_of_byte);
    assign w_load     = r_in_vld && w_res_free;
    assign o_in_ready = !r_in_vld || w_load;

    // --- decode of the registered byte, one step per code bit ---
    always_comb begin
        t_run zr;
        logic col;
        t_run bl;
        t_val acc;
        logic bt;
        zr  = r_zero_run;
        col = r_collecting;
        bl  = r_bits_left;
        acc = r_acc;
        n_res_vld = '0;
        n_res_err = '0;
        for (int i = int'(BYTE_W) - 1; i >= 0; i--) begin
            bt = r_in_byte[i];
            n_res_b[i] = '0;
            if (col) begin
                acc = {acc[VAL_W-2:0], bt};
                bl  = bl - t_run'(1);
                if (bl == '0) begin
                    n_res_vld[i] = 1'b1;
                    n_res_b[i]   = acc;
                    col          = 1'b0;
                    acc          = '0;
                end
            end else if (!bt) begin
                if (zr >= MaxRun) begin
                    // prefix overflow: error result, start a new prefix
                    n_res_vld[i] = 1'b1;
                    n_res_err[i] = 1'b1;
                    zr  = '0;
                    bl  = '0;
                    acc = '0;
                end else begin
                    zr = zr + t_run'(1);
                end
            end else if (zr == '0) begin
                n_res_vld[i] = 1'b1;
                n_res_b[i]   = t_val'(1);
            end else begin
                col = 1'b1;
                bl  = zr;
                acc = t_val'(1);
                zr  = '0;
            end
        end
        n_zero_run   = zr;
        n_collecting = col;
        n_bits_left  = bl;
        n_acc        = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_zero_run   <= '0;
            r_collecting <= 1'b0;
            r_bits_left  <= '0;
            r_acc        <= '0;
            r_res_vld    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_load) begin
                r_zero_run   <= n_zero_run;
                r_collecting <= n_collecting;
                r_bits_left  <= n_bits_left;
                r_acc        <= n_acc;
                r_res_vld    <= n_res_vld;
            end else if (w_fire_out) begin
                r_res_vld[w_sel] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (w_load) begin
            r_res_err <= n_res_err;
            r_res_b   <= n_res_b;
        end
    end

`ifndef SYNTH
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_prefix_error |-> o_decoded_value == '0)
        else $error("prefix error result carries a non-zero value");

    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero_run <= MaxRun)
        else $error("zero run beyond prefix limit");

    a_collect_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_collecting |-> r_bits_left != '0)
        else $error("suffix collection with no bits left");

    a_byte_not_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire_out && !o_last_of_byte |=> o_out_valid)
        else $error("results of a byte lost before its last one");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> $stable(r_zero_run) && $stable(r_collecting) && $stable(r_acc))
        else $error("decoder state moved without a byte");
`endif

endmodule
